/* rtl/bmg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmg_pkg - shared types and constants of the maze generator
// grid geometry, cell word layout, directions and sequencer states
// ----------------------------------------------------------------------------
package bmg_pkg;

   localparam int GRID_SIDE  = 6;
   localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int LEVEL_W    = $clog2(CELL_COUNT + 1);
   localparam int SIDE_W     = $clog2(GRID_SIDE);

   // fixed field widths of the stream items
   localparam int INDEX_W = 6;
   localparam int WALLS_W = 4;
   localparam int RAND_W  = 32;

   // cell word: four wall bits and a visited flag
   localparam int CELL_W            = 5;
   localparam int VISITED_BIT       = 4;
   localparam logic [CELL_W-1:0] WALLS_ALL = 5'h0F;
   localparam logic [CELL_W-1:0] VISITED   = 5'h10;
   localparam logic [CELL_W-1:0] WALL_UP    = 5'h01;
   localparam logic [CELL_W-1:0] WALL_RIGHT = 5'h02;
   localparam logic [CELL_W-1:0] WALL_DOWN  = 5'h04;
   localparam logic [CELL_W-1:0] WALL_LEFT  = 5'h08;

   typedef enum logic [1:0] {
      DIR_UP    = 2'd0,
      DIR_RIGHT = 2'd1,
      DIR_DOWN  = 2'd2,
      DIR_LEFT  = 2'd3
   } dir_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_TOP_RD,
      ST_TOP_LD,
      ST_SCAN,
      ST_CARVE,
      ST_DUMP_RD,
      ST_DUMP_LD
   } state_type;

   // random word reduced to what the pick needs
   typedef struct packed {
      logic [1:0] low2;
      logic [1:0] mod3;
   } rnd_sel_type;

   typedef struct packed {
      logic    found;
      dir_type dir;
   } pick_type;

   // wall of a cell facing the given direction
   function automatic logic [CELL_W-1:0] wall_of(input dir_type d);
      logic [CELL_W-1:0] w;
      unique case (d)
         DIR_UP:    w = WALL_UP;
         DIR_RIGHT: w = WALL_RIGHT;
         DIR_DOWN:  w = WALL_DOWN;
         DIR_LEFT:  w = WALL_LEFT;
         default:   w = WALL_UP;
      endcase
      return w;
   endfunction

   function automatic logic [CELL_W-1:0] wall_facing(input dir_type d);
      logic [CELL_W-1:0] w;
      unique case (d)
         DIR_UP:    w = WALL_DOWN;
         DIR_RIGHT: w = WALL_LEFT;
         DIR_DOWN:  w = WALL_UP;
         DIR_LEFT:  w = WALL_RIGHT;
         default:   w = WALL_DOWN;
      endcase
      return w;
   endfunction

   // 32-bit value mod 3 by folding: 2^16, 2^8, 2^4 and 2^2 are all 1 mod 3
   function automatic logic [1:0] mod3_of(input logic [RAND_W-1:0] v);
      logic [16:0] s1;
      logic [9:0]  s2;
      logic [6:0]  s3;
      logic [5:0]  s4;
      logic [3:0]  s5;
      logic [2:0]  s6;
      s1 = {1'b0, v[31:16]} + {1'b0, v[15:0]};
      s2 = {1'b0, s1[16:8]} + {2'b00, s1[7:0]};
      s3 = {1'b0, s2[9:4]} + {3'b000, s2[3:0]};
      s4 = {1'b0, s3[6:2]} + {4'b0000, s3[1:0]};
      s5 = s4[5:2] + {2'b00, s4[1:0]};
      s6 = {1'b0, s5[3:2]} + {1'b0, s5[1:0]};
      if (s6 >= 3'd3) begin
         s6 = s6 - 3'd3;
      end
      return s6[1:0];
   endfunction

   // row of a cell number, small compare table
   function automatic logic [SIDE_W-1:0] cell_row(input logic [ADDR_W-1:0] idx);
      logic [SIDE_W-1:0] r;
      r = '0;
      for (int k = 1; k < GRID_SIDE; k++) begin
         if (idx >= ADDR_W'(k * GRID_SIDE)) begin
            r = SIDE_W'(k);
         end
      end
      return r;
   endfunction

   function automatic logic [SIDE_W-1:0] cell_col(input logic [ADDR_W-1:0] idx);
      logic [SIDE_W-1:0] c;
      c = SIDE_W'(idx);
      for (int k = 1; k < GRID_SIDE; k++) begin
         if (idx >= ADDR_W'(k * GRID_SIDE)) begin
            c = SIDE_W'(idx - ADDR_W'(k * GRID_SIDE));
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

/* rtl/backtracking_maze_generator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// backtracking_maze_generator - depth-first maze builder
// cell words and the path stack sit in two single-port synchronous memories
// ----------------------------------------------------------------------------
// start item: accepted in ST_IDLE, then ST_CLEAR writes every cell word
// carving item: TOP_RD, TOP_LD, SCAN and CARVE, with TOP_RD to SCAN again for
//   each dead-end cell popped; one cell-memory read port, one neighbour a cycle
// dump: DUMP_RD reads each cell, DUMP_LD sends it, slower under back-pressure
// reset clears the sequencer, the output valid, the stack level and the
//   generating flag only; the memories are written by the start sweep first
module backtracking_maze_generator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] random_word
   input  wire logic        req_tuser,   // [0] start_req
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [5:0] cell_index, [9:6] cell_walls
   output logic             rsp_tlast    // last
);

   localparam int AW = bmg_pkg::ADDR_W;
   localparam int LW = bmg_pkg::LEVEL_W;
   localparam int SW = bmg_pkg::SIDE_W;
   localparam int CW = bmg_pkg::CELL_W;

   // memories
   logic [CW-1:0] cell_mem [bmg_pkg::CELL_COUNT];
   logic [AW-1:0] stack_mem [bmg_pkg::CELL_COUNT];

   logic          cell_we, cell_re, stack_we, stack_re;
   logic [AW-1:0] cell_waddr, cell_raddr, stack_waddr, stack_raddr;
   logic [CW-1:0] cell_wdata;
   logic [AW-1:0] stack_wdata;
   logic [CW-1:0] cell_rd_ff;
   logic [AW-1:0] stack_rd_ff;

   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_waddr] <= cell_wdata;
      end
      if (cell_re) begin
         cell_rd_ff <= cell_mem[cell_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_waddr] <= stack_wdata;
      end
      if (stack_re) begin
         stack_rd_ff <= stack_mem[stack_raddr];
      end
   end

   // sequencer registers
   bmg_pkg::state_type   state_ff, state_in;
   logic [AW-1:0]        count_ff, count_in;
   logic [2:0]           phase_ff, phase_in;
   logic [LW-1:0]        level_ff, level_in;
   logic                 gen_ff, gen_in;
   logic [AW-1:0]        top_ff, top_in;
   logic [SW-1:0]        row_ff, row_in;
   logic [SW-1:0]        col_ff, col_in;
   logic [3:0]           mask_ff, mask_in;
   logic                 prev_ok_ff, prev_ok_in;
   bmg_pkg::dir_type     dir_ff, dir_in;
   bmg_pkg::rnd_sel_type rnd_ff, rnd_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [bmg_pkg::INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [bmg_pkg::WALLS_W-1:0] rsp_walls_ff, rsp_walls_in;
   logic                       rsp_last_ff, rsp_last_in;

   bmg_pkg::pick_type pick;

   bmg_chooser u_chooser (
      .free_mask (mask_ff),
      .rnd_sel   (rnd_ff),
      .pick      (pick)
   );

   logic             req_accept;
   logic             out_free;
   bmg_pkg::dir_type scan_dir;
   logic             nb_ok;
   logic [AW-1:0]    nb_addr;
   logic [AW-1:0]    next_addr;

   assign req_tready = (state_ff == bmg_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign scan_dir   = bmg_pkg::dir_type'(phase_ff[1:0]);

   // neighbour under test in the scan
   always_comb begin
      unique case (scan_dir)
         bmg_pkg::DIR_UP: begin
            nb_ok   = (row_ff != '0);
            nb_addr = top_ff - AW'(bmg_pkg::GRID_SIDE);
         end
         bmg_pkg::DIR_RIGHT: begin
            nb_ok   = (col_ff != SW'(bmg_pkg::GRID_SIDE - 1));
            nb_addr = top_ff + AW'(1);
         end
         bmg_pkg::DIR_DOWN: begin
            nb_ok   = (row_ff != SW'(bmg_pkg::GRID_SIDE - 1));
            nb_addr = top_ff + AW'(bmg_pkg::GRID_SIDE);
         end
         bmg_pkg::DIR_LEFT: begin
            nb_ok   = (col_ff != '0);
            nb_addr = top_ff - AW'(1);
         end
         default: begin
            nb_ok   = 1'b0;
            nb_addr = top_ff;
         end
      endcase
   end

   always_comb begin
      unique case (dir_ff)
         bmg_pkg::DIR_UP:    next_addr = top_ff - AW'(bmg_pkg::GRID_SIDE);
         bmg_pkg::DIR_RIGHT: next_addr = top_ff + AW'(1);
         bmg_pkg::DIR_DOWN:  next_addr = top_ff + AW'(bmg_pkg::GRID_SIDE);
         bmg_pkg::DIR_LEFT:  next_addr = top_ff - AW'(1);
         default:            next_addr = top_ff;
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      phase_in   = phase_ff;
      level_in   = level_ff;
      gen_in     = gen_ff;
      top_in     = top_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      mask_in    = mask_ff;
      prev_ok_in = prev_ok_ff;
      dir_in     = dir_ff;
      rnd_in     = rnd_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_index_in = rsp_index_ff;
      rsp_walls_in = rsp_walls_ff;
      rsp_last_in  = rsp_last_ff;

      cell_we     = 1'b0;
      cell_waddr  = count_ff;
      cell_wdata  = bmg_pkg::WALLS_ALL;
      cell_re     = 1'b0;
      cell_raddr  = count_ff;
      stack_we    = 1'b0;
      stack_waddr = AW'(level_ff);
      stack_wdata = '0;
      stack_re    = 1'b0;
      stack_raddr = AW'(level_ff - LW'(1));

      unique case (state_ff)
         bmg_pkg::ST_IDLE: begin
            if (req_accept) begin
               rnd_in.low2 = req_tdata[1:0];
               rnd_in.mod3 = bmg_pkg::mod3_of(req_tdata);
               if (req_tuser) begin
                  // the start cell goes on the stack now, the sweep follows
                  stack_we    = 1'b1;
                  stack_waddr = '0;
                  stack_wdata = '0;
                  level_in    = LW'(1);
                  gen_in      = 1'b1;
                  count_in    = '0;
                  state_in    = bmg_pkg::ST_CLEAR;
               end else if (gen_ff) begin
                  state_in = bmg_pkg::ST_TOP_RD;
               end
            end
         end

         bmg_pkg::ST_CLEAR: begin
            cell_we    = 1'b1;
            cell_waddr = count_ff;
            cell_wdata = (count_ff == '0) ? (bmg_pkg::WALLS_ALL | bmg_pkg::VISITED)
                                          : bmg_pkg::WALLS_ALL;
            count_in   = count_ff + AW'(1);
            if (count_ff == AW'(bmg_pkg::CELL_COUNT - 1)) begin
               state_in = bmg_pkg::ST_IDLE;
            end
         end

         bmg_pkg::ST_TOP_RD: begin
            stack_re    = 1'b1;
            stack_raddr = AW'(level_ff - LW'(1));
            state_in    = bmg_pkg::ST_TOP_LD;
         end

         bmg_pkg::ST_TOP_LD: begin
            top_in   = stack_rd_ff;
            row_in   = bmg_pkg::cell_row(stack_rd_ff);
            col_in   = bmg_pkg::cell_col(stack_rd_ff);
            phase_in = 3'd0;
            mask_in  = 4'd0;
            state_in = bmg_pkg::ST_SCAN;
         end

         bmg_pkg::ST_SCAN: begin
            // read neighbours one a cycle, then the top cell itself
            if (phase_ff <= 3'd3) begin
               cell_re    = nb_ok;
               cell_raddr = nb_addr;
               prev_ok_in = nb_ok;
            end else if (phase_ff == 3'd4) begin
               cell_re    = 1'b1;
               cell_raddr = top_ff;
            end
            if (phase_ff >= 3'd1 && phase_ff <= 3'd4) begin
               mask_in[2'(phase_ff - 3'd1)] = prev_ok_ff && !cell_rd_ff[bmg_pkg::VISITED_BIT];
            end
            phase_in = phase_ff + 3'd1;
            if (phase_ff == 3'd5) begin
               if (pick.found) begin
                  cell_we    = 1'b1;
                  cell_waddr = top_ff;
                  cell_wdata = cell_rd_ff & ~bmg_pkg::wall_of(pick.dir);
                  dir_in     = pick.dir;
                  state_in   = bmg_pkg::ST_CARVE;
               end else begin
                  // dead end: pop
                  level_in = level_ff - LW'(1);
                  if (level_ff == LW'(1)) begin
                     gen_in   = 1'b0;
                     count_in = '0;
                     state_in = bmg_pkg::ST_DUMP_RD;
                  end else begin
                     state_in = bmg_pkg::ST_TOP_RD;
                  end
               end
            end
         end

         bmg_pkg::ST_CARVE: begin
            cell_we    = 1'b1;
            cell_waddr = next_addr;
            cell_wdata = (bmg_pkg::WALLS_ALL | bmg_pkg::VISITED) &
                         ~bmg_pkg::wall_facing(dir_ff);
            if (level_ff < LW'(bmg_pkg::CELL_COUNT)) begin
               stack_we    = 1'b1;
               stack_waddr = AW'(level_ff);
               stack_wdata = next_addr;
               level_in    = level_ff + LW'(1);
            end
            state_in = bmg_pkg::ST_IDLE;
         end

         bmg_pkg::ST_DUMP_RD: begin
            cell_re    = 1'b1;
            cell_raddr = count_ff;
            state_in   = bmg_pkg::ST_DUMP_LD;
         end

         bmg_pkg::ST_DUMP_LD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = bmg_pkg::INDEX_W'(count_ff);
               rsp_walls_in = cell_rd_ff[bmg_pkg::WALLS_W-1:0];
               rsp_last_in  = (count_ff == AW'(bmg_pkg::CELL_COUNT - 1));
               count_in     = count_ff + AW'(1);
               if (count_ff == AW'(bmg_pkg::CELL_COUNT - 1)) begin
                  state_in = bmg_pkg::ST_IDLE;
               end else begin
                  state_in = bmg_pkg::ST_DUMP_RD;
               end
            end
         end

         default: begin
            state_in = bmg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bmg_pkg::ST_IDLE;
         level_ff     <= '0;
         gen_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff     <= count_in;
      phase_ff     <= phase_in;
      top_ff       <= top_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      mask_ff      <= mask_in;
      prev_ok_ff   <= prev_ok_in;
      dir_ff       <= dir_in;
      rnd_ff       <= rnd_in;
      rsp_index_ff <= rsp_index_in;
      rsp_walls_ff <= rsp_walls_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_walls_ff, rsp_index_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

/* rtl/bmg_chooser.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmg_chooser - direction pick
// takes the free-neighbour mask and picks entry number (random mod count)
// ----------------------------------------------------------------------------
module bmg_chooser (
   input  wire logic [3:0]           free_mask,
   input  wire bmg_pkg::rnd_sel_type rnd_sel,
   output bmg_pkg::pick_type         pick
);

   logic [2:0] cnt;
   logic [1:0] sel;

   assign cnt = 3'($countones(free_mask));

   always_comb begin
      unique case (cnt)
         3'd2:    sel = {1'b0, rnd_sel.low2[0]};
         3'd3:    sel = rnd_sel.mod3;
         3'd4:    sel = rnd_sel.low2;
         default: sel = 2'd0;
      endcase
   end

   always_comb begin
      logic [2:0] seen;
      seen       = 3'd0;
      pick.found = 1'b0;
      pick.dir   = bmg_pkg::DIR_UP;
      for (int i = 0; i < 4; i++) begin
         if (free_mask[i]) begin
            if (seen == {1'b0, sel} && !pick.found) begin
               pick.found = 1'b1;
               pick.dir   = bmg_pkg::dir_type'(2'(i));
            end
            seen = seen + 3'd1;
         end
      end
   end

endmodule
`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - stream testbench for the depth-first maze generator
// items carrying a start flag or a random word go in; every accepted item
// is run through a local model of the maze walk, and the 36-cell wall dump
// that ends each maze is checked cell by cell against what the model built
// ----------------------------------------------------------------------------
module tb_top;

   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_WAIT  = 400;
   localparam int CALM_FROM   = 1200;
   localparam int CALM_TO     = 2400;
   localparam int RANDOM_ITEMS = 130;

   typedef struct packed {
      logic                       start;
      logic [bmg_pkg::RAND_W-1:0] word;
   } maze_req_type;

   typedef struct packed {
      logic [bmg_pkg::INDEX_W-1:0] cell_idx;
      logic [bmg_pkg::WALLS_W-1:0] walls;
      logic                        is_last;
   } cell_dump_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] random_word
   logic        req_tuser = 1'b0; // [0] start_req
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [5:0] cell_index, [9:6] cell_walls
   logic        rsp_tlast;

   maze_req_type  stim_items[$];
   cell_dump_type dump_cells[$];
   maze_req_type  next_item;
   cell_dump_type got_cell;
   cell_dump_type want_cell;

   // local copy of the maze state
   logic [bmg_pkg::CELL_W-1:0] cell_map[bmg_pkg::CELL_COUNT];
   int                         trail[bmg_pkg::CELL_COUNT];
   int                         trail_depth = 0;
   bit                         building = 1'b0;

   int  items_taken = 0;
   int  items_total = 0;
   int  mismatches  = 0;
   int  stall_cycles = 0;
   int  cycle_count  = 0;
   bit  quiet;

   backtracking_maze_generator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   assign quiet = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

   function automatic bit fresh(input int idx);
      return (cell_map[idx] & bmg_pkg::VISITED) == '0;
   endfunction

   // unvisited neighbours in the order up, right, down, left
   function automatic int free_dirs(input int idx, output bmg_pkg::dir_type cand[4]);
      int row;
      int col;
      int n;
      row = idx / bmg_pkg::GRID_SIDE;
      col = idx % bmg_pkg::GRID_SIDE;
      n = 0;
      cand = '{bmg_pkg::DIR_UP, bmg_pkg::DIR_UP, bmg_pkg::DIR_UP, bmg_pkg::DIR_UP};
      if (row > 0 && fresh(idx - bmg_pkg::GRID_SIDE)) begin
         cand[n] = bmg_pkg::DIR_UP;
         n++;
      end
      if (col < bmg_pkg::GRID_SIDE - 1 && fresh(idx + 1)) begin
         cand[n] = bmg_pkg::DIR_RIGHT;
         n++;
      end
      if (row < bmg_pkg::GRID_SIDE - 1 && fresh(idx + bmg_pkg::GRID_SIDE)) begin
         cand[n] = bmg_pkg::DIR_DOWN;
         n++;
      end
      if (col > 0 && fresh(idx - 1)) begin
         cand[n] = bmg_pkg::DIR_LEFT;
         n++;
      end
      return n;
   endfunction

   task automatic advance_maze(input logic start, input logic [bmg_pkg::RAND_W-1:0] word);
      int               top;
      int               n;
      int               nxt;
      bmg_pkg::dir_type cand[4];
      bmg_pkg::dir_type dir;
      top = 0;
      n = 0;
      if (start) begin
         for (int i = 0; i < bmg_pkg::CELL_COUNT; i++) begin
            cell_map[i] = bmg_pkg::WALLS_ALL;
         end
         cell_map[0] = bmg_pkg::WALLS_ALL | bmg_pkg::VISITED;
         trail[0] = 0;
         trail_depth = 1;
         building = 1'b1;
         return;
      end
      if (!building) begin
         return;
      end
      // back out of dead ends
      while (trail_depth > 0) begin
         top = trail[trail_depth - 1];
         n = free_dirs(top, cand);
         if (n > 0) begin
            break;
         end
         trail_depth--;
      end
      if (trail_depth == 0) begin
         building = 1'b0;
         for (int i = 0; i < bmg_pkg::CELL_COUNT; i++) begin
            dump_cells.push_back('{cell_idx: bmg_pkg::INDEX_W'(i),
                                   walls: cell_map[i][bmg_pkg::WALLS_W-1:0],
                                   is_last: (i == bmg_pkg::CELL_COUNT - 1)});
         end
         return;
      end
      dir = cand[word % bmg_pkg::RAND_W'(n)];
      case (dir)
         bmg_pkg::DIR_UP: begin
            nxt = top - bmg_pkg::GRID_SIDE;
            cell_map[top] &= ~bmg_pkg::WALL_UP;
            cell_map[nxt] &= ~bmg_pkg::WALL_DOWN;
         end
         bmg_pkg::DIR_RIGHT: begin
            nxt = top + 1;
            cell_map[top] &= ~bmg_pkg::WALL_RIGHT;
            cell_map[nxt] &= ~bmg_pkg::WALL_LEFT;
         end
         bmg_pkg::DIR_DOWN: begin
            nxt = top + bmg_pkg::GRID_SIDE;
            cell_map[top] &= ~bmg_pkg::WALL_DOWN;
            cell_map[nxt] &= ~bmg_pkg::WALL_UP;
         end
         default: begin
            nxt = top - 1;
            cell_map[top] &= ~bmg_pkg::WALL_LEFT;
            cell_map[nxt] &= ~bmg_pkg::WALL_RIGHT;
         end
      endcase
      cell_map[nxt] |= bmg_pkg::VISITED;
      if (trail_depth < bmg_pkg::CELL_COUNT) begin
         trail[trail_depth] = nxt;
         trail_depth++;
      end
   endtask

   function automatic logic [bmg_pkg::RAND_W-1:0] pick_word();
      logic [bmg_pkg::RAND_W-1:0] w;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: w = $urandom();
         6, 7:             w = $urandom_range(0, 11);
         8: begin
            case ($urandom_range(0, 3))
               0:       w = 32'h0000_0000;
               1:       w = 32'hFFFF_FFFF;
               2:       w = 32'h8000_0000;
               default: w = 32'h7FFF_FFFF;
            endcase
         end
         default:          w = 32'hFFFF_FFFF - $urandom_range(0, 11);
      endcase
      return w;
   endfunction

   // driver: one item per handshake, idles at random outside the calm stretch
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            advance_maze(req_tuser, req_tdata);
            items_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (stim_items.size() != 0 && (quiet || $urandom_range(0, 99) >= 37)) begin
               next_item = stim_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_item.word;
               req_tuser  <= next_item.start;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: back-pressure and cell-by-cell check of the dump
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet || ($urandom_range(0, 99) >= 37);
         if (rsp_tvalid && rsp_tready) begin
            got_cell = '{cell_idx: rsp_tdata[5:0], walls: rsp_tdata[9:6],
                         is_last: rsp_tlast};
            if (dump_cells.size() == 0) begin
               if (mismatches < 10) begin
                  $display("unexpected cell item: index %0d walls %h last %b",
                           got_cell.cell_idx, got_cell.walls, got_cell.is_last);
               end
               mismatches++;
            end else begin
               want_cell = dump_cells.pop_front();
               if (got_cell.cell_idx !== want_cell.cell_idx ||
                   got_cell.walls !== want_cell.walls ||
                   got_cell.is_last !== want_cell.is_last) begin
                  if (mismatches < 10) begin
                     $display({"cell mismatch: expected index %0d walls %h last %b, ",
                               "got index %0d walls %h last %b"},
                              want_cell.cell_idx, want_cell.walls, want_cell.is_last,
                              got_cell.cell_idx, got_cell.walls, got_cell.is_last);
                  end
                  mismatches++;
               end
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
         cycle_count  <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin
      int counted;
      int roll;
      int cut;
      // directed: ignored items while idle, start, carving with extreme words,
      // restart in the middle of a maze
      stim_items.push_back('{start: 1'b0, word: 32'h0000_0000});
      stim_items.push_back('{start: 1'b0, word: 32'hFFFF_FFFF});
      stim_items.push_back('{start: 1'b1, word: 32'hFFFF_FFFF});
      stim_items.push_back('{start: 1'b0, word: 32'h0000_0000});
      stim_items.push_back('{start: 1'b0, word: 32'hFFFF_FFFF});
      stim_items.push_back('{start: 1'b0, word: 32'h0000_0001});
      stim_items.push_back('{start: 1'b0, word: 32'h0000_0002});
      stim_items.push_back('{start: 1'b0, word: 32'h0000_0003});
      stim_items.push_back('{start: 1'b0, word: 32'h8000_0000});
      stim_items.push_back('{start: 1'b0, word: 32'h7FFF_FFFF});
      stim_items.push_back('{start: 1'b0, word: 32'h5555_5555});
      stim_items.push_back('{start: 1'b1, word: 32'h0000_0000});
      stim_items.push_back('{start: 1'b0, word: 32'hAAAA_AAAA});
      stim_items.push_back('{start: 1'b1, word: 32'h0000_0000});
      // random: mostly whole mazes (start plus 36 words), some cut short
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         cut = (roll < 80) ? bmg_pkg::CELL_COUNT
                           : $urandom_range(0, bmg_pkg::CELL_COUNT - 1);
         stim_items.push_back('{start: 1'b1, word: $urandom()});
         counted++;
         for (int i = 0; i < cut; i++) begin
            stim_items.push_back('{start: 1'b0, word: pick_word()});
            counted++;
         end
         // stray words while no maze is being built
         if (cut == bmg_pkg::CELL_COUNT && $urandom_range(0, 99) < 30) begin
            repeat ($urandom_range(1, 3)) begin
               stim_items.push_back('{start: 1'b0, word: $urandom()});
            end
         end
      end
      // finish on a complete maze
      stim_items.push_back('{start: 1'b1, word: $urandom()});
      for (int i = 0; i < bmg_pkg::CELL_COUNT; i++) begin
         stim_items.push_back('{start: 1'b0, word: pick_word()});
      end
      items_total = stim_items.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while ((items_taken < items_total || dump_cells.size() != 0) &&
             stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
      end
      if (stall_cycles < STALL_LIMIT) begin
         repeat (DRAIN_WAIT) @(posedge clock);
      end
      if (stall_cycles < STALL_LIMIT && mismatches == 0 && dump_cells.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* backtracking_maze_generator.f */
rtl/bmg_pkg.sv
rtl/bmg_chooser.sv
rtl/backtracking_maze_generator.sv
test/tb_top.sv
